### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the stopwatch timer pool.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define STP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define STP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define STP_ASSERT(lbl, clk, rst, prop)
`define STP_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### sv/stp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stopwatch timer pool package
// Sizes, command and status codes, and controller/datapath control types.
// ---------------------------------------------------------------------------
package stp_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int CMD_W = 3;
  localparam int ID_W = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int VALUE_W = 64;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADID = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

### sv/stp_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command and its timer id.
// ---------------------------------------------------------------------------
interface stp_req_if
  import stp_pkg::*;
;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0] timer_id;

  modport source (output valid, output command, output timer_id, input ready);
  modport sink (input valid, input command, input timer_id, output ready);
endinterface

### sv/stp_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the status, slot and value of one request.
// ---------------------------------------------------------------------------
interface stp_rsp_if
  import stp_pkg::*;
;
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output status, output slot, output value, input ready);
  modport sink (input valid, input status, input slot, input value, output ready);
endinterface

### sv/stp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stopwatch timer pool controller
// Two-state sequencer: accept a request, then execute it into the output
// register once that register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_ctrl
  import stp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       rsp_ready,
  input  dp_stat_t   stat,
  output logic       req_ready,
  output ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    req_ready = (state == ST_IDLE);
    cmd.load = req_ready && req_valid;
    cmd.exec = (state == ST_EXEC) && (!stat.out_full || rsp_ready);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.exec) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `STP_ASSERT(a_load_then_exec, clk, rst, cmd.load |=> (state == ST_EXEC))
  `STP_ASSERT_NEVER(a_no_load_in_exec, clk, rst, (state == ST_EXEC) && cmd.load)
  `STP_ASSERT(a_stall_holds, clk, rst,
    ((state == ST_EXEC) && stat.out_full && !rsp_ready) |=> (state == ST_EXEC))

endmodule

### sv/stp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stopwatch timer pool datapath
// Millisecond counter, slot flags and checkpoints, free-slot encoder,
// elapsed-time subtractor and the response register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_datapath
  import stp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic [CMD_W-1:0]        req_command,
  input  logic [ID_W-1:0]         req_timer_id,
  input  logic                    rsp_ready,
  output dp_stat_t                stat,
  output logic                    rsp_valid,
  output logic [STATUS_W-1:0]     rsp_status,
  output logic [SLOT_FIELD_W-1:0] rsp_slot,
  output logic [VALUE_W-1:0]      rsp_value
);

  logic [VALUE_W-1:0] millis;
  logic [SLOTS-1:0] slot_active;
  logic [VALUE_W-1:0] checkpoint [SLOTS];

  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0] id_q;

  logic id_ok;
  logic [SLOT_W-1:0] idx;
  logic free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [VALUE_W-1:0] elapsed;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic [VALUE_W-1:0] res_value;

  assign id_ok = (id_q < ID_W'(SLOTS));
  assign idx = id_q[SLOT_W-1:0];
  assign elapsed = millis - checkpoint[idx];
  assign stat.out_full = rsp_valid;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!slot_active[k]) begin
        free_found = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_slot = '0;
    res_value = '0;
    unique case (cmd_q)
      CMD_OPEN: begin
        if (free_found) begin
          res_slot = SLOT_FIELD_W'(free_idx);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        if (id_ok && slot_active[idx]) begin
          res_value = elapsed;
        end else begin
          res_status = ST_BADID;
        end
      end
      CMD_READ: res_value = millis;
      default: res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      millis <= '0;
      slot_active <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
        unique case (cmd_q)
          CMD_TICK: millis <= millis + VALUE_W'(1);
          CMD_OPEN: begin
            if (free_found) begin
              slot_active[free_idx] <= 1'b1;
            end
          end
          CMD_CLOSE: begin
            if (id_ok) begin
              slot_active[idx] <= 1'b0;
            end
          end
          default: millis <= millis;
        endcase
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= req_command;
      id_q <= req_timer_id;
    end
    if (cmd.exec) begin
      rsp_status <= res_status;
      rsp_slot <= res_slot;
      rsp_value <= res_value;
      unique case (cmd_q)
        CMD_OPEN: begin
          if (free_found) begin
            checkpoint[free_idx] <= millis;
          end
        end
        CMD_RESTART: begin
          if (id_ok) begin
            checkpoint[idx] <= millis;
          end
        end
        CMD_CLOSE: begin
          if (id_ok) begin
            checkpoint[idx] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `STP_ASSERT(a_open_full, clk, rst,
    (cmd.exec && (cmd_q == CMD_OPEN) && (&slot_active)) |=> (rsp_status == ST_FULL))

endmodule

### sv/stopwatch_timer_pool_core.sv
`timescale 1ns / 1ps
// A request accepted into the command register is executed into the response
// register once that register is free or its response is being taken. The
// accept/execute controller takes no new request until the current one has
// executed, with one slot read-modify-write per request. The response register
// frees the input side while a response waits to be taken. Reset: synchronous rst
// clears the counter, all slot flags and the handshakes; there is no clearing pass.
// ---------------------------------------------------------------------------
// Stopwatch timer pool core
// Free-running millisecond counter with a pool of stopwatch slots.
// ---------------------------------------------------------------------------
module stopwatch_timer_pool_core
  import stp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  stp_req_if.sink   req,
  stp_rsp_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t stat;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  stp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_command  (req.command),
    .req_timer_id (req.timer_id),
    .rsp_ready    (rsp.ready),
    .stat         (stat),
    .rsp_valid    (rsp.valid),
    .rsp_status   (rsp.status),
    .rsp_slot     (rsp.slot),
    .rsp_value    (rsp.value)
  );

endmodule

### bench/stopwatch_timer_pool_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stopwatch timer pool core testbench
// Drives directed and random commands through the request channel. Random
// gaps and stalls are applied on both channels. A scoreboard predicts the
// counter and slot state and checks every response field by field.
// ---------------------------------------------------------------------------
module stopwatch_timer_pool_core_tb;
  import stp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1280;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [VALUE_W-1:0]      value;
  } timer_result_t;

  class timer_pool_scoreboard;
    bit [VALUE_W-1:0] now_ms;
    bit               slot_busy[SLOTS];
    bit [VALUE_W-1:0] slot_mark[SLOTS];
    timer_result_t    expected_q[$];
    int               errors;

    function void clear();
      now_ms = '0;
      for (int k = 0; k < SLOTS; k++) begin
        slot_busy[k] = 1'b0;
        slot_mark[k] = '0;
      end
      expected_q.delete();
      errors = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      timer_result_t r;
      bit            id_ok;
      bit            found;
      int            idx;
      r = '0;
      id_ok = (int'(id) < SLOTS);
      idx = id_ok ? int'(id) : 0;
      found = 1'b0;
      case (cmd)
        CMD_TICK: begin
          now_ms = now_ms + 1'b1;
        end
        CMD_OPEN: begin
          r.status = ST_FULL;
          for (int k = 0; k < SLOTS; k++) begin
            if (!found && !slot_busy[k]) begin
              found = 1'b1;
              slot_busy[k] = 1'b1;
              slot_mark[k] = now_ms;
              r.status = ST_OK;
              r.slot = k[SLOT_FIELD_W-1:0];
            end
          end
        end
        CMD_QUERY: begin
          if (id_ok && slot_busy[idx]) begin
            r.value = now_ms - slot_mark[idx];
          end else begin
            r.status = ST_BADID;
          end
        end
        CMD_RESTART: begin
          if (id_ok) begin
            slot_mark[idx] = now_ms;
          end
        end
        CMD_CLOSE: begin
          if (id_ok) begin
            slot_busy[idx] = 1'b0;
            slot_mark[idx] = '0;
          end
        end
        CMD_READ: begin
          r.value = now_ms;
        end
        default: begin
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_response(logic [STATUS_W-1:0] st, logic [SLOT_FIELD_W-1:0] sl,
                        logic [VALUE_W-1:0] val);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        report("response arrived with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0d want %0d", st, want.status));
      if (sl !== want.slot)
        report($sformatf("slot got %0d want %0d", sl, want.slot));
      if (val !== want.value)
        report($sformatf("value got %h want %h", val, want.value));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   req_gaps_on;
  bit   rsp_gaps_on;
  bit   hold_rsp;
  int   cycle_count;

  timer_pool_scoreboard pool_sb;

  stp_req_if req_ch ();
  stp_rsp_if rsp_ch ();

  stopwatch_timer_pool_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85)
      return ID_W'($urandom_range(0, SLOTS - 1));
    return ID_W'($urandom_range(SLOTS, 255));
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = req_gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.timer_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    pool_sb.note_request(cmd, id);
  endtask

  task automatic wait_for_responses();
    while (pool_sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = rsp_gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      pool_sb.check_response(rsp_ch.status, rsp_ch.slot, rsp_ch.value);
    end
  end

  initial begin
    int                 roll;
    logic [CMD_W-1:0]   cmd;
    pool_sb = new();
    pool_sb.clear();
    cycle_count = 0;
    req_gaps_on = 1'b0;
    rsp_gaps_on = 1'b0;
    hold_rsp = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TICK;
    req_ch.timer_id = '0;
    rsp_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A fresh pool: counter at zero, every slot inactive.
    send_request(CMD_READ, 8'h00);
    send_request(CMD_QUERY, 8'h00);
    send_request(CMD_SPARE6, 8'hA5);
    send_request(CMD_SPARE7, 8'h5A);
    send_request(CMD_RESTART, 8'h10);
    send_request(CMD_CLOSE, 8'hFF);
    send_request(CMD_TICK, 8'h00);
    for (int k = 0; k < SLOTS; k++) begin
      if (k == SLOTS / 2) send_request(CMD_TICK, 8'h00);
      send_request(CMD_OPEN, 8'h00);
    end
    send_request(CMD_OPEN, 8'h00);
    send_request(CMD_QUERY, 8'h00);
    send_request(CMD_QUERY, 8'hFF);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        req_gaps_on = ($urandom_range(0, 2) != 0);
        rsp_gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (n == 300) begin
        req_gaps_on = 1'b0;
        hold_rsp = 1'b1;
      end
      if (n == 700) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_for_responses();
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) cmd = CMD_TICK;
      else if (roll < 45) cmd = CMD_OPEN;
      else if (roll < 70) cmd = CMD_QUERY;
      else if (roll < 80) cmd = CMD_RESTART;
      else if (roll < 92) cmd = CMD_CLOSE;
      else if (roll < 97) cmd = CMD_READ;
      else if (roll[0]) cmd = CMD_SPARE6;
      else cmd = CMD_SPARE7;
      send_request(cmd, pick_id());
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/stp_pkg.sv
sv/stp_req_if.sv
sv/stp_rsp_if.sv
sv/stp_ctrl.sv
sv/stp_datapath.sv
sv/stopwatch_timer_pool_core.sv
bench/stopwatch_timer_pool_core_tb.sv
